// File: rtl/assert_macros.svh
// Assertion macros for the block's concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLKD(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// File: rtl/uvse_pkg.sv
// Package: types and constants of the unique value extractor.
`timescale 1ns / 1ps
`default_nettype none

package uvse_pkg;

	localparam int VALUE_W = 10;
	localparam int CNT_W   = 2;

	localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 10'd1000;

	localparam logic [CNT_W-1:0] COUNT_ZERO = 2'd0;
	localparam logic [CNT_W-1:0] COUNT_ONE  = 2'd1;
	localparam logic [CNT_W-1:0] COUNT_MANY = 2'd2;

	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic               opcode;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] unique_value;
		logic               done_res;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/uvse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module uvse_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/unique_value_sorted_extract.sv
// Top level: occurrence count store and ascending extraction of values seen exactly once.
// Count item: busy for one cycle (ST_COUNT write back) after accept; an ignored value leaves busy low.
// Read item: strobed from a register once the hit is found, each store entry skipped before the hit
//   lengthening the item; the scan reads one entry per cycle from the count RAM.
// Done result: strobed after the remaining entries are scanned, as a clearing pass of every RAM
//   entry with busy high begins. Results cannot be stalled by the receiver.
// Reset: the same clearing pass; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module unique_value_sorted_extract #(
	parameter int VALUE_SLOTS = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire uvse_pkg::cmd_t               cmd,
	input  wire logic                         cfg_we,
	input  wire logic [uvse_pkg::VALUE_W-1:0] cfg_wdata,
	output logic                              res_valid,
	output uvse_pkg::res_t                    res
);

	import uvse_pkg::*;

	localparam int AW = $clog2(VALUE_SLOTS);
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] POS_END  = PW'(VALUE_SLOTS);
	localparam logic [AW-1:0] ADDR_TOP = AW'(VALUE_SLOTS - 1);

	state_t             state_q, state_d;
	logic [VALUE_W-1:0] max_q;
	logic [PW-1:0]      scan_q, scan_d;
	logic [PW-1:0]      issue_q, issue_d;
	logic [AW-1:0]      clr_q, clr_d;
	logic               pend_s1, pend_d;
	logic [AW-1:0]      pend_addr_s1, pend_addr_d;
	logic [AW-1:0]      cnt_addr_q, cnt_addr_d;
	logic               res_valid_q, res_valid_d;
	res_t               res_q, res_d;

	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [CNT_W-1:0]   mem_wdata, mem_rdata;

	logic               accept, in_range, hit;

	assign accept   = start && (state_q == ST_IDLE);
	assign in_range = (cmd.value <= max_q) && (32'(cmd.value) < 32'(VALUE_SLOTS));
	assign hit      = pend_s1 && (mem_rdata == COUNT_ONE);

	uvse_ram #(
		.WIDTH (CNT_W),
		.DEPTH (VALUE_SLOTS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d     = state_q;
		scan_d      = scan_q;
		issue_d     = issue_q;
		clr_d       = clr_q;
		pend_d      = 1'b0;
		pend_addr_d = pend_addr_s1;
		cnt_addr_d  = cnt_addr_q;
		res_valid_d = 1'b0;
		res_d       = res_q;
		mem_we      = 1'b0;
		mem_waddr   = cnt_addr_q;
		mem_wdata   = COUNT_ZERO;
		mem_re      = 1'b0;
		mem_raddr   = AW'(cmd.value);
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				clr_d     = clr_q + 1'b1;
				if (clr_q == ADDR_TOP) begin
					clr_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (cmd.opcode == OP_READ) begin
						issue_d = scan_q;
						state_d = ST_SCAN;
					end else if (in_range) begin
						mem_re     = 1'b1;
						cnt_addr_d = AW'(cmd.value);
						state_d    = ST_COUNT;
					end
				end
			end
			ST_COUNT: begin
				mem_we    = 1'b1;
				mem_wdata = (mem_rdata >= COUNT_MANY) ? mem_rdata : mem_rdata + 1'b1;
				state_d   = ST_IDLE;
			end
			ST_SCAN: begin
				if (hit) begin
					res_valid_d        = 1'b1;
					res_d.unique_value = VALUE_W'(pend_addr_s1);
					res_d.done_res     = 1'b0;
					scan_d             = PW'(pend_addr_s1) + 1'b1;
					state_d            = ST_IDLE;
				end else if (!pend_s1 && (issue_q == POS_END)) begin
					res_valid_d        = 1'b1;
					res_d.unique_value = '0;
					res_d.done_res     = 1'b1;
					scan_d             = '0;
					clr_d              = '0;
					state_d            = ST_CLEAR;
				end else if (issue_q != POS_END) begin
					mem_re      = 1'b1;
					mem_raddr   = issue_q[AW-1:0];
					pend_d      = 1'b1;
					pend_addr_d = issue_q[AW-1:0];
					issue_d     = issue_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			max_q       <= MAX_VALUE_RESET;
			scan_q      <= '0;
			issue_q     <= '0;
			clr_q       <= '0;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_q      <= scan_d;
			issue_q     <= issue_d;
			clr_q       <= clr_d;
			pend_s1     <= pend_d;
			res_valid_q <= res_valid_d;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_s1 <= pend_addr_d;
		cnt_addr_q   <= cnt_addr_d;
		res_q        <= res_d;
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_CLKD(a_done_zero, clk, arst_n, res_valid && res.done_res |-> res.unique_value == '0, "done result with nonzero value")
	`ASSERT_CLKD(a_done_clears, clk, arst_n, res_valid && res.done_res |-> state_q == ST_CLEAR, "done result without clearing pass")
	`ASSERT_CLKD(a_res_from_scan, clk, arst_n, res_valid |-> $past(state_q == ST_SCAN), "result outside a scan")
	`ASSERT_CLKD(a_count_busy, clk, arst_n, accept && cmd.opcode == OP_COUNT && in_range |=> busy && state_q == ST_COUNT, "count item skipped its write back")
	`ASSERT_ALWAYS(a_no_rw_clash, clk, !(mem_we && mem_re), "count RAM read and written in one cycle")

endmodule

`default_nettype wire

// File: sim/unique_value_sorted_extract_tb.sv
// Testbench for unique_value_sorted_extract: random and directed items against a predictor.
`timescale 1ns / 1ps

module unique_value_sorted_extract_tb;
	import uvse_pkg::*;

	localparam int VALUE_SLOTS = 1024;
	localparam int ITEM_TARGET = 1100;

	typedef enum logic [1:0] {
		PLAN_ITEM,
		PLAN_CFG,
		PLAN_DRAIN
	} plan_kind_t;

	typedef struct {
		plan_kind_t         kind;
		cmd_t               cmd;
		logic [VALUE_W-1:0] cfg;
		int                 gap;
	} plan_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	cmd_t               cmd       = '0;
	logic               cfg_we    = 1'b0;
	logic [VALUE_W-1:0] cfg_wdata = '0;
	logic               busy;
	logic               res_valid;
	res_t               res;

	unique_value_sorted_extract u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_valid (res_valid),
		.res       (res)
	);

	always #5 clk = ~clk;

	// predicted block state
	logic [CNT_W-1:0]   occ_cnt [VALUE_SLOTS];
	int unsigned        scan_pos;
	logic [VALUE_W-1:0] max_val;

	plan_t item_plan[$];
	res_t  pending_uniques[$];
	int    errors = 0;

	// generator state
	bit                 burst = 1'b0;
	int                 planned = 0;

	task automatic clear_counts();
		foreach (occ_cnt[i])
			occ_cnt[i] = COUNT_ZERO;
		scan_pos = 0;
	endtask

	task automatic track_item(input cmd_t c);
		res_t r;
		int unsigned pos;
		bit hit;
		hit = 1'b0;
		r = '0;
		if (c.opcode == OP_COUNT) begin
			if (c.value <= max_val && c.value < VALUE_SLOTS && occ_cnt[c.value] < COUNT_MANY)
				occ_cnt[c.value] = occ_cnt[c.value] + 1'b1;
		end else begin
			while (!hit && scan_pos < VALUE_SLOTS) begin
				pos = scan_pos;
				scan_pos++;
				if (occ_cnt[pos] == COUNT_ONE) begin
					hit = 1'b1;
					r.unique_value = pos[VALUE_W-1:0];
				end
			end
			if (!hit) begin
				r.done_res = 1'b1;
				clear_counts();
			end
			pending_uniques.push_back(r);
		end
	endtask

	task automatic report_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic add_item(input logic op, input logic [VALUE_W-1:0] v);
		plan_t p;
		p.kind = PLAN_ITEM;
		p.cmd.opcode = op;
		p.cmd.value = v;
		p.cfg = '0;
		p.gap = burst ? 0 : $urandom_range(0, 5);
		item_plan.push_back(p);
		planned++;
	endtask

	task automatic add_cfg(input logic [VALUE_W-1:0] v);
		plan_t p;
		p.kind = PLAN_CFG;
		p.cmd = '0;
		p.cfg = v;
		p.gap = 0;
		item_plan.push_back(p);
	endtask

	task automatic add_drain();
		plan_t p;
		p.kind = PLAN_DRAIN;
		p.cmd = '0;
		p.cfg = '0;
		p.gap = 0;
		item_plan.push_back(p);
	endtask

	// driver
	int gap_wait = 0;
	int quiet = 0;

	always @(posedge clk) begin : drive
		plan_t nxt;
		logic  nxt_start;
		logic  nxt_we;
		nxt_start = start;
		nxt_we = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				track_item(cmd);
				nxt_start = 1'b0;
			end
			quiet = (!busy && !start && !res_valid && pending_uniques.size() == 0) ? quiet + 1 : 0;
			if (!nxt_start && item_plan.size() != 0) begin
				nxt = item_plan[0];
				case (nxt.kind)
					PLAN_ITEM: begin
						if (gap_wait < nxt.gap) begin
							gap_wait++;
						end else begin
							gap_wait = 0;
							void'(item_plan.pop_front());
							cmd <= nxt.cmd;
							nxt_start = 1'b1;
						end
					end
					PLAN_CFG: begin
						if (quiet >= 4) begin
							void'(item_plan.pop_front());
							nxt_we = 1'b1;
							cfg_wdata <= nxt.cfg;
							max_val = nxt.cfg;
						end
					end
					default: begin
						if (!res_valid && pending_uniques.size() == 0)
							void'(item_plan.pop_front());
					end
				endcase
			end
		end
		start <= nxt_start;
		cfg_we <= nxt_we;
	end

	// monitor
	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n && res_valid) begin
			if (pending_uniques.size() == 0) begin
				report_error($sformatf("unexpected result value %0d done %0b",
					res.unique_value, res.done_res));
			end else begin
				want = pending_uniques.pop_front();
				if (res.unique_value !== want.unique_value || res.done_res !== want.done_res)
					report_error($sformatf("expected value %0d done %0b, got value %0d done %0b",
						want.unique_value, want.done_res, res.unique_value, res.done_res));
			end
		end
	end

	initial begin
		#80_000_000;
		$display("unique_value_sorted_extract_tb: errors");
		$finish;
	end

	initial begin
		int n;
		int reads;
		int span;
		int base;
		bit full;
		logic [VALUE_W-1:0] v;

		max_val = MAX_VALUE_RESET;
		clear_counts();

		// directed
		add_item(OP_COUNT, 10'd0);
		add_item(OP_COUNT, 10'd1023);
		add_item(OP_COUNT, 10'd1000);
		add_item(OP_COUNT, 10'd1001);
		add_item(OP_COUNT, 10'd5);
		add_item(OP_COUNT, 10'd5);
		add_item(OP_COUNT, 10'd7);
		add_item(OP_READ, 10'd0);
		add_item(OP_COUNT, 10'd0);
		add_item(OP_READ, 10'd1023);
		add_item(OP_READ, 10'd0);
		add_item(OP_READ, 10'd0);
		add_item(OP_READ, 10'd0);
		add_drain();
		add_cfg(10'd1023);
		add_item(OP_COUNT, 10'd1023);
		add_item(OP_READ, 10'd0);
		add_item(OP_COUNT, 10'd10);
		add_cfg(10'd5);
		add_item(OP_COUNT, 10'd10);
		add_item(OP_COUNT, 10'd4);
		add_item(OP_READ, 10'd0);
		add_item(OP_READ, 10'd0);
		add_item(OP_READ, 10'd0);
		add_cfg(10'd0);
		add_item(OP_COUNT, 10'd0);
		add_item(OP_COUNT, 10'd1);
		add_item(OP_READ, 10'd0);
		add_item(OP_READ, 10'd0);
		add_cfg(MAX_VALUE_RESET);

		// random sets: counts with mostly clustered values and occasional reads, then a read-out
		while (planned < ITEM_TARGET) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0, 1: add_cfg(10'd1023);
					2: add_cfg(VALUE_W'($urandom_range(0, 1023)));
					default: add_cfg(MAX_VALUE_RESET);
				endcase
			end
			burst = ($urandom_range(0, 3) == 0);
			n = $urandom_range(1, 24);
			full = ($urandom_range(0, 7) == 0);
			span = $urandom_range(4, 64);
			base = $urandom_range(0, 1023 - span);
			for (int i = 0; i < n; i++) begin
				v = full ? VALUE_W'($urandom_range(0, 1023))
					: VALUE_W'(base + $urandom_range(0, span));
				add_item(OP_COUNT, v);
				if ($urandom_range(0, 9) == 0)
					add_item(OP_READ, VALUE_W'($urandom_range(0, 1023)));
			end
			reads = $urandom_range(n / 3, n / 2 + 2);
			for (int i = 0; i < reads; i++)
				add_item(OP_READ, VALUE_W'($urandom_range(0, 1023)));
			if ($urandom_range(0, 19) == 0)
				add_drain();
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (item_plan.size() != 0 || start || pending_uniques.size() != 0);
		repeat (VALUE_SLOTS + 64) @(posedge clk);

		if (pending_uniques.size() != 0)
			report_error($sformatf("%0d expected results never arrived",
				pending_uniques.size()));

		if (errors == 0)
			$display("unique_value_sorted_extract_tb: clean");
		else
			$display("unique_value_sorted_extract_tb: errors");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/uvse_pkg.sv
rtl/uvse_ram.sv
rtl/unique_value_sorted_extract.sv
sim/unique_value_sorted_extract_tb.sv
